>>> hdl/acfb_pkg.sv
// shared types, frame templates and byte functions for the ir frame builder
package acfb_pkg;

    localparam int FRAME_LEN = 13;
    localparam logic [3:0] LAST_POS = 4'(FRAME_LEN - 1);
    localparam logic [3:0] TEMP_POS = 4'd4;
    localparam logic [3:0] POWER_POS = 4'd5;
    localparam logic [3:0] FAN_POS = 4'd6;

    localparam logic [7:0] POWER_MAX = 8'd1;
    localparam logic [7:0] MODE_MAX = 8'd1;
    localparam logic [7:0] FAN_MAX = 8'd3;
    localparam logic [7:0] TEMP_MIN = 8'd16;
    localparam logic [7:0] TEMP_MAX = 8'd30;
    localparam logic [7:0] TEMP_BIAS = 8'd17;
    localparam logic [7:0] OFF_BYTE5 = 8'h21;

    localparam logic [1:0] WARM_FAN = 2'd3;
    localparam logic [7:0] WARM_TEMP = 8'd20;

    localparam logic [7:0] BASE_FRAME [0:FRAME_LEN-1] = '{
        8'hAA, 8'h5A, 8'hCF, 8'h10, 8'h00, 8'h11, 8'h21,
        8'h0E, 8'h08, 8'h80, 8'h04, 8'hF0, 8'h01};
    localparam logic [7:0] TEN_FRAME [0:FRAME_LEN-1] = '{
        8'hAA, 8'h5A, 8'hCF, 8'h10, 8'h00, 8'h31, 8'h71,
        8'h0B, 8'h08, 8'h80, 8'h05, 8'hF0, 8'h91};
    localparam logic [7:0] FAN_CODES [0:3] = '{8'h21, 8'h31, 8'h51, 8'h71};

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_WARM   = 2'd1,
        KIND_TEN    = 2'd2
    } frame_kind_t;

    typedef struct packed {
        logic [7:0] power_request;
        logic [7:0] ten_degree_mode;
        logic [7:0] fan_level;
        logic [7:0] target_temperature;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0]  frame_byte;
        logic [3:0]  byte_position;
        frame_kind_t frame_kind;
        logic        rejected;
        logic        last_of_run;
    } frame_beat_t;

    // checked and narrowed command
    typedef struct packed {
        logic       ok;
        logic       ten;
        logic       on;
        logic [1:0] fan;
        logic [7:0] temp;
    } cmd_info_t;

    // template byte with the command fields applied, checksum nibble not yet merged
    function automatic logic [7:0] frame_byte(input logic ten, input logic on,
                                              input logic [1:0] fan,
                                              input logic [7:0] temp,
                                              input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx <= LAST_POS) begin
            b = ten ? TEN_FRAME[idx] : BASE_FRAME[idx];
            if (!ten) begin
                if (!on && idx == POWER_POS) begin
                    b = OFF_BYTE5;
                end
                if (on && idx == TEMP_POS) begin
                    b = temp - TEMP_BIAS;
                end
                if (on && idx == FAN_POS) begin
                    b = FAN_CODES[fan];
                end
            end
        end
        return b;
    endfunction

    // xor of bytes 0..11 and the low nibble of byte 12, folded to a nibble
    function automatic logic [3:0] frame_csum(input logic ten, input logic on,
                                              input logic [1:0] fan,
                                              input logic [7:0] temp);
        logic [7:0] c;
        c = frame_byte(ten, on, fan, temp, LAST_POS) & 8'h0F;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            c = c ^ frame_byte(ten, on, fan, temp, 4'(i));
        end
        return c[7:4] ^ c[3:0];
    endfunction

endpackage

>>> hdl/aircon_ir_frame_builder.sv
// top level of the air-conditioner ir frame builder
//
//   channel | direction | handshake          | beat payload
//   s_      | in        | s_valid / s_ready  | cmd_beat_t: power, mode, fan, temperature
//   m_      | out       | m_valid / m_ready  | frame_beat_t: one frame byte with tags
//
// one result beat per cycle while m_ready is high: a rejected command gives one beat, a
// normal command one frame and a ten-degree command a warm-up frame then the fixed frame
// the next command is taken into the input register while the final byte of the
// previous one is still being loaded or waiting in the output register
// aresetn clears the valid flags and the byte counter; data registers are not reset
// a stalled m_ready holds the output register and the byte counter in place
module aircon_ir_frame_builder
    import acfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cmd_beat_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output frame_beat_t m_data
);

    logic      cmd_valid_reg, cmd_valid_next;
    cmd_beat_t cmd_reg, cmd_next;
    cmd_info_t info;
    logic      info_done;

    assign s_ready = !cmd_valid_reg || info_done;

    always_comb begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && !info_done;
        if (s_valid && s_ready) begin
            cmd_next       = s_data;
            cmd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    acfb_cmd_check u_check (
        .cmd  (cmd_reg),
        .info (info)
    );

    acfb_byte_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .info_valid (cmd_valid_reg),
        .info       (info),
        .info_done  (info_done),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> hdl/acfb_cmd_check.sv
// range check of one command and narrowing of its fields
module acfb_cmd_check
    import acfb_pkg::*;
(
    input  cmd_beat_t cmd,
    output cmd_info_t info
);

    always_comb begin
        info.ok   = (cmd.power_request <= POWER_MAX) && (cmd.ten_degree_mode <= MODE_MAX)
                 && (cmd.fan_level <= FAN_MAX)
                 && (cmd.target_temperature >= TEMP_MIN)
                 && (cmd.target_temperature <= TEMP_MAX);
        info.ten  = cmd.ten_degree_mode[0];
        info.on   = cmd.power_request[0];
        info.fan  = cmd.fan_level[1:0];
        info.temp = cmd.target_temperature;
    end

endmodule

>>> hdl/acfb_byte_seq.sv
// walks the frame bytes of one command into the output register
module acfb_byte_seq
    import acfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        info_valid,
    input  cmd_info_t   info,
    output logic        info_done,
    output logic        m_valid,
    input  logic        m_ready,
    output frame_beat_t m_data
);

    logic [3:0]  pos_reg, pos_next;
    logic        second_reg, second_next;
    logic        m_valid_reg, m_valid_next;
    frame_beat_t m_data_reg, m_data_next;

    logic        advance;
    logic        is_last;
    logic        use_ten;
    logic        eff_on;
    logic [1:0]  eff_fan;
    logic [7:0]  eff_temp;
    logic [7:0]  cur_byte;
    frame_kind_t cur_kind;

    assign advance = info_valid && (!m_valid_reg || m_ready);

    always_comb begin
        // ten-degree commands: warm-up frame first, then the fixed frame
        use_ten  = info.ten && second_reg;
        eff_on   = info.ten ? 1'b1 : info.on;
        eff_fan  = info.ten ? WARM_FAN : info.fan;
        eff_temp = info.ten ? WARM_TEMP : info.temp;
        if (!info.ten) begin
            cur_kind = KIND_NORMAL;
        end else if (second_reg) begin
            cur_kind = KIND_TEN;
        end else begin
            cur_kind = KIND_WARM;
        end
        cur_byte = frame_byte(use_ten, eff_on, eff_fan, eff_temp, pos_reg);
        if (pos_reg == LAST_POS) begin
            cur_byte = cur_byte | {frame_csum(use_ten, eff_on, eff_fan, eff_temp), 4'h0};
        end
        is_last = !info.ok || (pos_reg == LAST_POS && (!info.ten || second_reg));
    end

    always_comb begin
        pos_next     = pos_reg;
        second_next  = second_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (advance) begin
            m_valid_next = 1'b1;
            if (!info.ok) begin
                m_data_next.frame_byte    = 8'h00;
                m_data_next.byte_position = 4'd0;
                m_data_next.frame_kind    = KIND_NORMAL;
                m_data_next.rejected      = 1'b1;
            end else begin
                m_data_next.frame_byte    = cur_byte;
                m_data_next.byte_position = pos_reg;
                m_data_next.frame_kind    = cur_kind;
                m_data_next.rejected      = 1'b0;
            end
            m_data_next.last_of_run = is_last;
            if (is_last) begin
                pos_next    = 4'd0;
                second_next = 1'b0;
            end else if (pos_reg == LAST_POS) begin
                pos_next    = 4'd0;
                second_next = 1'b1;
            end else begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 4'd0;
            second_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            second_reg  <= second_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign info_done = advance && is_last;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

>>> hdl/acfb_checker.sv
// port-level checks of the frame builder and their bind
module acfb_checker
    import acfb_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input frame_beat_t m_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // a rejected command's beat is empty and closes its run
    a_reject_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> m_data.last_of_run && m_data.frame_byte == 8'h00
            && m_data.byte_position == 4'd0 && m_data.frame_kind == KIND_NORMAL)
        else $error("malformed rejected beat");

    // a run that is not rejected ends only on the final byte of a normal or ten-degree frame
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_of_run && !m_data.rejected |->
            m_data.byte_position == LAST_POS && m_data.frame_kind != KIND_WARM)
        else $error("run ended inside a frame");

    // every frame opens with the fixed header byte
    a_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.rejected && m_data.byte_position == 4'd0 |->
            m_data.frame_byte == BASE_FRAME[0])
        else $error("frame does not start with the header byte");

endmodule

bind aircon_ir_frame_builder acfb_checker u_acfb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> verif/tb_aircon_ir_frame_builder.sv
// testbench for the air-conditioner ir frame builder: random commands checked beat by beat
class frame_scoreboard;

    localparam int FRAME_BYTES = 13;
    localparam logic [7:0] NORMAL_TEMPLATE [FRAME_BYTES] = '{
        8'hAA, 8'h5A, 8'hCF, 8'h10, 8'h00, 8'h11, 8'h21,
        8'h0E, 8'h08, 8'h80, 8'h04, 8'hF0, 8'h01};
    localparam logic [7:0] TEN_TEMPLATE [FRAME_BYTES] = '{
        8'hAA, 8'h5A, 8'hCF, 8'h10, 8'h00, 8'h31, 8'h71,
        8'h0B, 8'h08, 8'h80, 8'h05, 8'hF0, 8'h91};
    localparam logic [7:0] FAN_BYTE [4] = '{8'h21, 8'h31, 8'h51, 8'h71};
    localparam logic [7:0] OFF_CODE = 8'h21;

    acfb_pkg::frame_beat_t bytes_due[$];
    logic [7:0] frame_work [FRAME_BYTES];
    int errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return bytes_due.size();
    endfunction

    task report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function void load_normal(input bit on, input logic [1:0] fan, input logic [7:0] temp);
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_work[i] = NORMAL_TEMPLATE[i];
        end
        if (!on) begin
            frame_work[5] = OFF_CODE;
        end else begin
            // wraps below 17 degrees
            frame_work[4] = 8'(8'd1 + temp - 8'd18);
            frame_work[6] = FAN_BYTE[fan];
        end
    endfunction

    function void load_ten();
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_work[i] = TEN_TEMPLATE[i];
        end
    endfunction

    // fold the xor of the frame into the high nibble of the last byte
    function void seal_work();
        logic [7:0] acc;
        acc = frame_work[FRAME_BYTES-1] & 8'h0F;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            acc = acc ^ frame_work[i];
        end
        acc = acc ^ (acc >> 4);
        frame_work[FRAME_BYTES-1] = frame_work[FRAME_BYTES-1] | {acc[3:0], 4'h0};
    endfunction

    function void queue_work(input acfb_pkg::frame_kind_t kind, input bit closes_run);
        acfb_pkg::frame_beat_t b;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            b.frame_byte = frame_work[i];
            b.byte_position = 4'(i);
            b.frame_kind = kind;
            b.rejected = 1'b0;
            b.last_of_run = closes_run && (i == FRAME_BYTES - 1);
            bytes_due.push_back(b);
        end
    endfunction

    function void note_command(input acfb_pkg::cmd_beat_t c);
        acfb_pkg::frame_beat_t b;
        if (c.power_request > 8'd1 || c.ten_degree_mode > 8'd1 || c.fan_level > 8'd3 ||
            c.target_temperature < 8'd16 || c.target_temperature > 8'd30) begin
            b.frame_byte = 8'h00;
            b.byte_position = 4'd0;
            b.frame_kind = acfb_pkg::KIND_NORMAL;
            b.rejected = 1'b1;
            b.last_of_run = 1'b1;
            bytes_due.push_back(b);
        end else if (c.ten_degree_mode == 8'd1) begin
            // warm-up frame: on, fan high, 20 degrees
            load_normal(1'b1, 2'd3, 8'd20);
            seal_work();
            queue_work(acfb_pkg::KIND_WARM, 1'b0);
            load_ten();
            seal_work();
            queue_work(acfb_pkg::KIND_TEN, 1'b1);
        end else begin
            load_normal(c.power_request[0], c.fan_level[1:0], c.target_temperature);
            seal_work();
            queue_work(acfb_pkg::KIND_NORMAL, 1'b1);
        end
    endfunction

    task check_beat(input acfb_pkg::frame_beat_t got);
        acfb_pkg::frame_beat_t want;
        if (bytes_due.size() == 0) begin
            report($sformatf("beat with nothing pending: byte=%02h pos=%0d kind=%0d rej=%b last=%b",
                             got.frame_byte, got.byte_position, got.frame_kind,
                             got.rejected, got.last_of_run));
        end else begin
            want = bytes_due.pop_front();
            if (got.frame_byte !== want.frame_byte ||
                got.byte_position !== want.byte_position ||
                got.frame_kind !== want.frame_kind ||
                got.rejected !== want.rejected ||
                got.last_of_run !== want.last_of_run) begin
                report($sformatf({"want byte=%02h pos=%0d kind=%0d rej=%b last=%b, ",
                                  "got byte=%02h pos=%0d kind=%0d rej=%b last=%b"},
                                 want.frame_byte, want.byte_position, want.frame_kind,
                                 want.rejected, want.last_of_run,
                                 got.frame_byte, got.byte_position, got.frame_kind,
                                 got.rejected, got.last_of_run));
            end
        end
    endtask

endclass

module tb_aircon_ir_frame_builder
    import acfb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_CMDS = 430;
    localparam int CALM_TAIL = 60;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 40;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    cmd_beat_t   s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    frame_beat_t m_data;

    frame_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;

    aircon_ir_frame_builder u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // receiver: random stall bursts with m_ready held low
    always @(posedge aclk) begin
        if (stall_left == 0 && recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 9);
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_beat(m_data);
        end
    end

    function automatic cmd_beat_t make_cmd(input logic [7:0] pwr, input logic [7:0] mode,
                                           input logic [7:0] fan, input logic [7:0] temp);
        cmd_beat_t c;
        c.power_request = pwr;
        c.ten_degree_mode = mode;
        c.fan_level = fan;
        c.target_temperature = temp;
        return c;
    endfunction

    // mostly well-formed commands, the rest with one field out of range or pure noise
    function automatic cmd_beat_t random_cmd();
        cmd_beat_t c;
        c = make_cmd(8'($urandom_range(0, 1)), 8'($urandom_range(0, 4) == 0),
                     8'($urandom_range(0, 3)), 8'($urandom_range(16, 30)));
        if ($urandom_range(0, 99) < 22) begin
            case ($urandom_range(0, 4))
                0: c.power_request = 8'($urandom_range(2, 255));
                1: c.ten_degree_mode = 8'($urandom_range(2, 255));
                2: c.fan_level = 8'($urandom_range(4, 255));
                3: c.target_temperature = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                               : 8'($urandom_range(31, 255));
                default: c = cmd_beat_t'($urandom);
            endcase
        end
        return c;
    endfunction

    function automatic int pick_gap();
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            return $urandom_range(1, 9);
        end
        return 0;
    endfunction

    task automatic send_cmd(input cmd_beat_t c, input int gap);
        s_data <= c;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_command(c);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the sender until every pending beat has come out
    task automatic drain_frames();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, power off, temperature wrap, ten-degree, rejects
        send_cmd(make_cmd(8'd0, 8'd0, 8'd0, 8'd16), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd0, 8'd16), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd1, 8'd17), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd2, 8'd18), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd3, 8'd30), 0);
        send_cmd(make_cmd(8'd0, 8'd0, 8'd3, 8'd30), 0);
        send_cmd(make_cmd(8'd1, 8'd1, 8'd0, 8'd16), 0);
        send_cmd(make_cmd(8'd0, 8'd1, 8'd3, 8'd30), 0);
        send_cmd(make_cmd(8'd2, 8'd0, 8'd0, 8'd20), 0);
        send_cmd(make_cmd(8'd255, 8'd0, 8'd0, 8'd20), 0);
        send_cmd(make_cmd(8'd0, 8'd2, 8'd0, 8'd20), 0);
        send_cmd(make_cmd(8'd0, 8'd255, 8'd0, 8'd20), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd4, 8'd20), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd255, 8'd20), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd0, 8'd15), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd0, 8'd31), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd0, 8'd0), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd0, 8'd255), 0);
        send_cmd(make_cmd(8'd0, 8'd0, 8'd1, 8'd22), 0);
        send_cmd(make_cmd(8'd1, 8'd1, 8'd4, 8'd20), 0);
        send_cmd(make_cmd(8'd1, 8'd1, 8'd0, 8'd31), 0);
        send_cmd(make_cmd(8'd1, 8'd0, 8'd2, 8'd25), 0);
        drain_frames();

        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 48 == 0) begin
                case ($urandom_range(0, 3))
                    0: send_idle_pct = 0;
                    1: send_idle_pct = 5;
                    2: send_idle_pct = 20;
                    default: send_idle_pct = 50;
                endcase
                case ($urandom_range(0, 3))
                    0: recv_idle_pct = 0;
                    1: recv_idle_pct = 3;
                    2: recv_idle_pct = 10;
                    default: recv_idle_pct = 25;
                endcase
            end
            if (n >= RANDOM_CMDS - CALM_TAIL) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n == RANDOM_CMDS / 2) begin
                drain_frames();
            end
            send_cmd(random_cmd(), pick_gap());
        end

        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
